[rtl/assert_macros.svh]
// assertion macros shared by the debye sum block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define DSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define DSA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define DSA_ASSERT(lbl, prop, msg)
`define DSA_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

[rtl/dsa_pkg.sv]
// types, constants and helpers of the debye sum accumulator
package dsa_pkg;

  localparam int NPTS_DEF     = 4096;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 20;
  localparam int NUM_POINTS_W = 13;
  localparam int SCALE_W      = 20;

  localparam logic [NUM_POINTS_W-1:0] NUM_POINTS_RST = 13'd4096;
  localparam logic [SCALE_W-1:0]      SCALE_RST      = 20'd65536;

  // serial divider geometry, used for the final reciprocal only
  localparam int DVD_W  = 55;
  localparam int DVS_W  = 46;
  localparam int ITER_W = 6;

  localparam logic [ITER_W-1:0] ITER_RECIP = 6'd55;

  localparam logic [26:0] TWO_PI_Q24  = 27'd105414357;
  localparam logic [26:0] PI_Q24      = 27'd52707179;
  localparam logic [26:0] HALF_PI_Q24 = 27'd26353589;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [2:0]  HORNER_LAST = 3'd5;

  // floor(2^50 / two pi), applied to x >> 20; turn count comes out at most one low
  localparam logic [23:0] TWO_PI_RECIP = 24'd10680707;

  localparam logic [63:0] ACC_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ACC_MIN = 64'h8000_0000_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_POINTS,
    CFG_LATTICE_SCALE
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_LOAD,
    MODE_CLEAR,
    MODE_ADD,
    MODE_READ
  } mode_t;

  typedef struct packed {
    mode_t        mode;
    logic [11:0]  point_index;
    logic [23:0]  q_value;
    logic [31:0]  multiplicity;
    logic [21:0]  distance;
    logic [31:0]  weight;
    logic         use_scale;
  } dsa_in_t;

  typedef struct packed {
    logic signed [63:0] intensity;
    logic [11:0]        point_index_res;
  } dsa_out_t;

  typedef enum logic [4:0] {
    DP_NONE,
    DP_LATCH,
    DP_LOAD_Q,
    DP_CLR_WR,
    DP_OUT,
    DP_WM,
    DP_T,
    DP_X,
    DP_MOD,
    DP_MOD_R,
    DP_FOLD,
    DP_R2,
    DP_HP,
    DP_HDIV,
    DP_HUPD,
    DP_S,
    DP_DX,
    DP_SINC,
    DP_LO,
    DP_HI,
    DP_TERM,
    DP_ACC_WR
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] k_sel;
  } dsa_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  no_points;
    logic  last_point;
    logic  clr_last;
    logic  div_done;
  } dsa_stat_t;

  typedef enum logic [4:0] {
    ST_INIT_CLR,
    ST_IDLE,
    ST_DISPATCH,
    ST_LOAD,
    ST_CLR,
    ST_RD_OUT,
    ST_WM,
    ST_FETCH,
    ST_T,
    ST_X,
    ST_MOD,
    ST_MOD_R,
    ST_FOLD,
    ST_R2,
    ST_HP,
    ST_HDIV,
    ST_HUPD,
    ST_S,
    ST_DX,
    ST_DX_W,
    ST_SINC,
    ST_LO,
    ST_HI,
    ST_TERM,
    ST_ACC
  } ctrl_state_t;

  // taylor horner divisors, innermost first
  function automatic logic [7:0] horner_div(input logic [2:0] k);
    logic [7:0] d;
    case (k)
      3'd0:    d = 8'd156;
      3'd1:    d = 8'd110;
      3'd2:    d = 8'd72;
      3'd3:    d = 8'd42;
      3'd4:    d = 8'd20;
      3'd5:    d = 8'd6;
      default: d = 8'd6;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor), quotient estimate is at most one low
  function automatic logic [29:0] horner_recip(input logic [2:0] k);
    logic [29:0] m;
    case (k)
      3'd0:    m = 30'd27531841;
      3'd1:    m = 30'd39045157;
      3'd2:    m = 30'd59652323;
      3'd3:    m = 30'd102261126;
      3'd4:    m = 30'd214748364;
      3'd5:    m = 30'd715827882;
      default: m = 30'd715827882;
    endcase
    return m;
  endfunction

endpackage

[rtl/dsa_ram.sv]
// generic single write, single read ram with registered read
module dsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/dsa_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
module dsa_div
  import dsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [DVS_W-1:0]  divisor,
  input  logic [ITER_W-1:0] iters,
  output logic [DVD_W-1:0]  quotient,
  output logic              done,
  output logic              running
);

  logic [DVD_W-1:0]  sh;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs;
  logic [ITER_W-1:0] cnt;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              ge;

  always_comb begin
    trial = {rem, sh[DVD_W-1]};
    ge    = trial >= {1'b0, dvs};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && (cnt == ITER_W'(1));
      if (start) begin
        running <= 1'b1;
        cnt     <= iters;
      end else if (running) begin
        cnt <= cnt - ITER_W'(1);
        if (cnt == ITER_W'(1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  // dividend arrives left aligned, quotient bits shift in from the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (running) begin
      sh  <= {sh[DVD_W-2:0], ge};
      rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign quotient = sh;

endmodule

[rtl/dsa_datapath.sv]
// datapath: registers, q and accumulator memories, sinc arithmetic
`include "assert_macros.svh"
module dsa_datapath #(
  parameter int NPTS = dsa_pkg::NPTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  dsa_pkg::dsa_in_t            item,
  input  logic                        cfg_we,
  input  logic [dsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dsa_pkg::CFG_DATA_W-1:0] cfg_data,
  input  dsa_pkg::dsa_cmd_t           cmd,
  output dsa_pkg::dsa_stat_t          stat,
  output logic                        result_valid,
  output dsa_pkg::dsa_out_t           result
);
  import dsa_pkg::*;

  localparam int AW = $clog2(NPTS);

  dsa_in_t                 it;
  logic [AW-1:0]           addr;
  logic [NUM_POINTS_W-1:0] num_points;
  logic [SCALE_W-1:0]      lattice_scale;

  logic [23:0] q_rd;
  logic [63:0] acc_rd;
  logic        q_we;
  logic        acc_we;
  logic [63:0] acc_wdata;

  logic [63:0] wm;
  logic [41:0] t;
  logic [45:0] x;
  logic [19:0] mod_q;
  logic [27:0] r_mod;
  logic        neg;
  logic [30:0] big_r;
  logic [31:0] r2;
  logic [30:0] p;
  logic [31:0] hp;
  logic [29:0] hq;
  logic [31:0] s_raw;
  logic [30:0] sinc;
  logic [62:0] prod_lo;
  logic [62:0] prod_hi;
  logic [50:0] mag;

  logic [45:0] mul_t;
  logic [61:0] mul_x;
  logic [49:0] mul_qe;
  logic [46:0] mul_qc;
  logic [45:0] mod_diff;
  logic [61:0] mul_r2;
  logic [62:0] mul_hp;
  logic [61:0] mul_hq;
  logic [37:0] mul_hk;
  logic [31:0] h_rem;
  logic [29:0] h_quo;
  logic [61:0] mul_s;
  logic [62:0] mul_lo;
  logic [62:0] mul_hi;
  logic [63:0] mul_wm;

  logic [27:0] r_sub;
  logic [26:0] r0;
  logic [26:0] r1;
  logic [26:0] rf;
  logic        ge_pi;
  logic [94:0] term_sum;
  logic [64:0] acc_ext;
  logic [64:0] acc_sum;
  logic [63:0] acc_new;
  logic [30:0] v_lim;
  logic        in_range;

  logic              div_start;
  logic [DVD_W-1:0]  div_dvd;
  logic [DVS_W-1:0]  div_dvs;
  logic [ITER_W-1:0] div_iters;
  logic [DVD_W-1:0]  div_quo;
  logic              div_done;
  logic              div_running;

  dsa_ram #(.WIDTH(24), .DEPTH(NPTS)) u_q_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (addr),
    .wdata (it.q_value),
    .raddr (addr),
    .rdata (q_rd)
  );

  dsa_ram #(.WIDTH(64), .DEPTH(NPTS)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (addr),
    .wdata (acc_wdata),
    .raddr (addr),
    .rdata (acc_rd)
  );

  dsa_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .iters     (div_iters),
    .quotient  (div_quo),
    .done      (div_done),
    .running   (div_running)
  );

  always_comb begin
    in_range = 32'(it.point_index) < NPTS;

    mul_wm = 64'(it.weight) * 64'(it.multiplicity);
    mul_t  = 46'(q_rd) * 46'(it.distance);
    mul_x  = 62'(t) * 62'(lattice_scale);
    mul_r2 = 62'(big_r) * 62'(big_r);
    mul_hp = 63'(r2) * 63'(p);
    mul_s  = 62'(big_r) * 62'(p);
    mul_lo = 63'(wm[31:0]) * 63'(sinc);
    mul_hi = 63'(wm[63:32]) * 63'(sinc);

    // turn count estimate, then remainder below two full turns
    mul_qe   = 50'(x[45:20]) * 50'(TWO_PI_RECIP);
    mul_qc   = 47'(mod_q) * 47'(TWO_PI_Q24);
    mod_diff = x - mul_qc[45:0];

    // horner step: quotient estimate, then one correction against the remainder
    mul_hq = 62'(hp) * 62'(horner_recip(cmd.k_sel));
    mul_hk = 38'(hq) * 38'(horner_div(cmd.k_sel));
    h_rem  = hp - mul_hk[31:0];
    h_quo  = (h_rem >= 32'(horner_div(cmd.k_sel))) ? (hq + 30'd1) : hq;

    // fold the angle into the first quadrant
    r_sub = r_mod - 28'(TWO_PI_Q24);
    r0    = (r_mod >= 28'(TWO_PI_Q24)) ? r_sub[26:0] : r_mod[26:0];
    ge_pi = r0 >= PI_Q24;
    r1    = ge_pi ? (r0 - PI_Q24) : r0;
    rf    = (r1 > HALF_PI_Q24) ? (PI_Q24 - r1) : r1;

    v_lim = (div_quo > DVD_W'(ONE_Q30)) ? ONE_Q30 : div_quo[30:0];

    term_sum = {prod_hi, 32'd0} + 95'(prod_lo);

    acc_ext = {acc_rd[63], acc_rd};
    acc_sum = neg ? (acc_ext - 65'(mag)) : (acc_ext + 65'(mag));
    if (acc_sum[64] != acc_sum[63]) begin
      acc_new = acc_sum[64] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_new = acc_sum[63:0];
    end

    q_we      = (cmd.op == DP_LOAD_Q) && in_range;
    acc_we    = (cmd.op == DP_CLR_WR) || (cmd.op == DP_ACC_WR);
    acc_wdata = (cmd.op == DP_ACC_WR) ? acc_new : 64'd0;

    div_start = cmd.op == DP_DX;
    div_dvd   = {s_raw[30:0], 24'd0};
    div_dvs   = x;
    div_iters = ITER_RECIP;

    stat.mode       = it.mode;
    stat.no_points  = num_points == '0;
    stat.last_point = (32'(addr) + 32'd1 >= 32'(num_points)) || (32'(addr) == NPTS - 1);
    stat.clr_last   = 32'(addr) == NPTS - 1;
    stat.div_done   = div_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_points    <= NUM_POINTS_RST;
      lattice_scale <= SCALE_RST;
      addr          <= '0;
      result_valid  <= 1'b0;
    end else begin
      result_valid <= cmd.op == DP_OUT;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_NUM_POINTS:    num_points    <= cfg_data[NUM_POINTS_W-1:0];
          CFG_LATTICE_SCALE: lattice_scale <= cfg_data[SCALE_W-1:0];
          default: ;
        endcase
      end
      case (cmd.op)
        DP_LATCH: begin
          if ((item.mode == MODE_LOAD) || (item.mode == MODE_READ)) begin
            addr <= AW'(item.point_index);
          end else begin
            addr <= '0;
          end
        end
        DP_CLR_WR, DP_ACC_WR: addr <= addr + AW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LATCH: it <= item;
      DP_OUT: begin
        result.intensity       <= in_range ? acc_rd : 64'sd0;
        result.point_index_res <= it.point_index;
      end
      DP_WM:    wm    <= mul_wm;
      DP_T:     t     <= mul_t[45:4];
      DP_X:     x     <= it.use_scale ? mul_x[61:16] : 46'(t);
      DP_MOD:   mod_q <= mul_qe[49:30];
      DP_MOD_R: r_mod <= mod_diff[27:0];
      DP_FOLD: begin
        neg   <= ge_pi;
        big_r <= {rf[24:0], 6'd0};
      end
      DP_R2: begin
        r2 <= mul_r2[61:30];
        p  <= ONE_Q30;
      end
      DP_HP:   hp    <= mul_hp[61:30];
      DP_HDIV: hq    <= mul_hq[61:32];
      DP_HUPD: p     <= ONE_Q30 - {1'b0, h_quo};
      DP_S:    s_raw <= mul_s[61:30];
      DP_SINC: begin
        if (x == '0) begin
          sinc <= ONE_Q30;
          neg  <= 1'b0;
        end else begin
          sinc <= v_lim;
          if (v_lim == '0) begin
            neg <= 1'b0;
          end
        end
      end
      DP_LO:   prod_lo <= mul_lo;
      DP_HI:   prod_hi <= mul_hi;
      DP_TERM: mag     <= term_sum[94:44];
      default: ;
    endcase
  end

  `DSA_ASSERT(a_div_start_idle, div_start |-> !div_running, "divider restarted while running")
  `DSA_ASSERT_NEXT(a_result_single, result_valid, !result_valid, "result strobe held two cycles")
  `DSA_ASSERT(a_no_dual_write, !(q_we && acc_we), "q and accumulator written together")

endmodule

[rtl/dsa_ctrl.sv]
// controller state machine sequencing the datapath per item and per point
`include "assert_macros.svh"
module dsa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  dsa_pkg::dsa_stat_t  stat,
  output dsa_pkg::dsa_cmd_t   cmd,
  output logic                busy
);
  import dsa_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic [2:0]  kidx;
  logic [2:0]  kidx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT_CLR;
      kidx  <= '0;
    end else begin
      state <= state_next;
      kidx  <= kidx_next;
    end
  end

  always_comb begin
    state_next = state;
    kidx_next  = kidx;
    cmd.op     = DP_NONE;
    cmd.k_sel  = kidx;
    busy       = state != ST_IDLE;
    case (state)
      // accumulator sweep after reset
      ST_INIT_CLR: begin
        cmd.op = DP_CLR_WR;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.op     = DP_LATCH;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (stat.mode)
          MODE_LOAD:  state_next = ST_LOAD;
          MODE_CLEAR: state_next = ST_CLR;
          MODE_ADD:   state_next = ST_WM;
          MODE_READ:  state_next = ST_RD_OUT;
          default:    state_next = ST_IDLE;
        endcase
      end
      ST_LOAD: begin
        cmd.op     = DP_LOAD_Q;
        state_next = ST_IDLE;
      end
      ST_CLR: begin
        cmd.op = DP_CLR_WR;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_RD_OUT: begin
        cmd.op     = DP_OUT;
        state_next = ST_IDLE;
      end
      ST_WM: begin
        cmd.op     = DP_WM;
        state_next = stat.no_points ? ST_IDLE : ST_T;
      end
      // memory read latency after the point address moves
      ST_FETCH: state_next = ST_T;
      ST_T: begin
        cmd.op     = DP_T;
        state_next = ST_X;
      end
      ST_X: begin
        cmd.op     = DP_X;
        state_next = ST_MOD;
      end
      ST_MOD: begin
        cmd.op     = DP_MOD;
        state_next = ST_MOD_R;
      end
      ST_MOD_R: begin
        cmd.op     = DP_MOD_R;
        state_next = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.op     = DP_FOLD;
        state_next = ST_R2;
      end
      ST_R2: begin
        cmd.op     = DP_R2;
        kidx_next  = '0;
        state_next = ST_HP;
      end
      ST_HP: begin
        cmd.op     = DP_HP;
        state_next = ST_HDIV;
      end
      ST_HDIV: begin
        cmd.op     = DP_HDIV;
        state_next = ST_HUPD;
      end
      ST_HUPD: begin
        cmd.op = DP_HUPD;
        if (kidx == HORNER_LAST) begin
          state_next = ST_S;
        end else begin
          kidx_next  = kidx + 3'd1;
          state_next = ST_HP;
        end
      end
      ST_S: begin
        cmd.op     = DP_S;
        state_next = ST_DX;
      end
      ST_DX: begin
        cmd.op     = DP_DX;
        state_next = ST_DX_W;
      end
      ST_DX_W: begin
        if (stat.div_done) begin
          state_next = ST_SINC;
        end
      end
      ST_SINC: begin
        cmd.op     = DP_SINC;
        state_next = ST_LO;
      end
      ST_LO: begin
        cmd.op     = DP_LO;
        state_next = ST_HI;
      end
      ST_HI: begin
        cmd.op     = DP_HI;
        state_next = ST_TERM;
      end
      ST_TERM: begin
        cmd.op     = DP_TERM;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.op     = DP_ACC_WR;
        state_next = stat.last_point ? ST_IDLE : ST_FETCH;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `DSA_ASSERT(a_kidx_range, kidx <= HORNER_LAST, "horner index past last divisor")
  `DSA_ASSERT(a_done_in_wait, stat.div_done |-> state == ST_DX_W, "divider done outside wait")
  `DSA_ASSERT_NEXT(a_next_point, state == ST_ACC && !stat.last_point, state == ST_FETCH, "point loop did not continue")

endmodule

[rtl/debye_sum_accumulator.sv]
// top level of the debye sum intensity accumulator
// One item is taken while busy is low; busy stays high until its work is done.
// A clear item zeroes all NPTS accumulators, and an add item runs one pass per
// active point: the angle reduction and the six horner divisions use
// reciprocal multiplies with one correction step, and the final reciprocal runs
// through a bit-serial divider of 55 steps, which takes most of each pass.
// After reset a clearing pass over all NPTS entries zeroes the accumulators
// while busy is high; configuration writes are taken throughout.
// Results are strobed for one cycle and cannot be held off.
module debye_sum_accumulator #(
  parameter int NPTS = dsa_pkg::NPTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  dsa_pkg::dsa_in_t               item,
  input  logic                           cfg_we,
  input  logic [dsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dsa_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           result_valid,
  output dsa_pkg::dsa_out_t              result
);
  import dsa_pkg::*;

  dsa_cmd_t  cmd;
  dsa_stat_t stat;

  dsa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  dsa_datapath #(.NPTS(NPTS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

[tb/testbench.sv]
// self-checking testbench of the debye sum intensity accumulator
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPTS = dsa_pkg::NPTS_DEF;
  localparam logic [63:0] TAU_Q24 = 64'd105414357;
  localparam logic [63:0] HALF_TURN_Q24 = 64'd52707179;
  localparam logic [63:0] QUARTER_TURN_Q24 = 64'd26353589;
  localparam logic [63:0] UNIT_Q30 = 64'd1 << 30;
  localparam int QUIET_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  dsa_pkg::dsa_in_t item = '0;
  logic cfg_we = 1'b0;
  logic [dsa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [dsa_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic result_valid;
  dsa_pkg::dsa_out_t result;

  debye_sum_accumulator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .result(result)
  );

  // predictor state
  logic [23:0] q_mem [NPTS];
  logic signed [63:0] acc_mem [NPTS];
  logic [12:0] active_points = 13'd4096;
  logic [19:0] scale_q16 = 20'd65536;

  dsa_pkg::dsa_in_t pending [$];
  dsa_pkg::dsa_out_t expected_reads [$];
  bit loaded [NPTS];
  bit took = 0;
  bit idle_on = 1;
  int gap_left = 0;
  int quiet = 0;
  int errors = 0;
  int n_load = 0, n_clear = 0, n_add = 0, n_read = 0, n_checked = 0;

  initial forever #5 clk = ~clk;

  // sinc magnitude in Q.30, sign returned separately
  function automatic logic [63:0] sinc_q30(input logic [63:0] x, output logic neg);
    logic [63:0] r, big_r, r2, p, s, v, d;
    neg = 1'b0;
    if (x == 0) return UNIT_Q30;
    r = x % TAU_Q24;
    if (r >= HALF_TURN_Q24) begin
      r = r - HALF_TURN_Q24;
      neg = 1'b1;
    end
    if (r > QUARTER_TURN_Q24) r = HALF_TURN_Q24 - r;
    big_r = r << 6;
    r2 = (big_r * big_r) >> 30;
    p = UNIT_Q30;
    for (int k = 0; k < 6; k++) begin
      case (k)
        0: d = 156;
        1: d = 110;
        2: d = 72;
        3: d = 42;
        4: d = 20;
        default: d = 6;
      endcase
      p = UNIT_Q30 - (((r2 * p) >> 30) / d);
    end
    s = (big_r * p) >> 30;
    v = (s << 24) / x;
    if (v > UNIT_Q30) v = UNIT_Q30;
    if (v == 0) neg = 1'b0;
    return v;
  endfunction

  task automatic add_term(input dsa_pkg::dsa_in_t it);
    logic [63:0] wm, x, s;
    logic [127:0] prod;
    logic neg;
    logic signed [64:0] sum;
    int n;
    wm = 64'(it.weight) * 64'(it.multiplicity);
    n = active_points > NPTS ? NPTS : int'(active_points);
    for (int j = 0; j < n; j++) begin
      x = (64'(q_mem[j]) * 64'(it.distance)) >> 4;
      if (it.use_scale) x = (x * 64'(scale_q16)) >> 16;
      s = sinc_q30(x, neg);
      prod = (128'(wm) * 128'(s)) >> 44;
      if (neg) sum = {acc_mem[j][63], acc_mem[j]} - $signed({1'b0, prod[63:0]});
      else sum = {acc_mem[j][63], acc_mem[j]} + $signed({1'b0, prod[63:0]});
      if (sum > 65'sh0_7FFF_FFFF_FFFF_FFFF) acc_mem[j] = 64'sh7FFF_FFFF_FFFF_FFFF;
      else if (sum < -65'sh0_8000_0000_0000_0000) acc_mem[j] = 64'sh8000_0000_0000_0000;
      else acc_mem[j] = sum[63:0];
    end
  endtask

  task automatic predict_item(input dsa_pkg::dsa_in_t it);
    dsa_pkg::dsa_out_t r;
    case (it.mode)
      dsa_pkg::MODE_LOAD: begin
        q_mem[it.point_index] = it.q_value;
        n_load++;
      end
      dsa_pkg::MODE_CLEAR: begin
        for (int j = 0; j < NPTS; j++) acc_mem[j] = '0;
        n_clear++;
      end
      dsa_pkg::MODE_ADD: begin
        add_term(it);
        n_add++;
      end
      default: begin
        r.intensity = acc_mem[it.point_index];
        r.point_index_res = it.point_index;
        expected_reads.push_back(r);
        n_read++;
      end
    endcase
  endtask

  // acceptance, register shadow, result check and watchdog
  always @(posedge clk) begin
    took = 0;
    if (rst) begin
      for (int j = 0; j < NPTS; j++) begin
        q_mem[j] = '0;
        acc_mem[j] = '0;
      end
      active_points = 13'd4096;
      scale_q16 = 20'd65536;
      quiet = 0;
    end else begin
      quiet++;
      if (cfg_we) begin
        if (cfg_index == dsa_pkg::CFG_NUM_POINTS) active_points = cfg_data[12:0];
        else if (cfg_index == dsa_pkg::CFG_LATTICE_SCALE) scale_q16 = cfg_data;
      end
      if (start && !busy) begin
        predict_item(pending.pop_front());
        took = 1;
        quiet = 0;
      end
      if (result_valid) begin
        quiet = 0;
        if (expected_reads.size() == 0) begin
          $error("unexpected result: intensity %0d point %0d",
                 result.intensity, result.point_index_res);
          errors++;
        end else begin
          if (result.intensity !== expected_reads[0].intensity) begin
            $error("intensity: expected %0d actual %0d",
                   expected_reads[0].intensity, result.intensity);
            errors++;
          end
          if (result.point_index_res !== expected_reads[0].point_index_res) begin
            $error("point_index_res: expected %0d actual %0d",
                   expected_reads[0].point_index_res, result.point_index_res);
            errors++;
          end
          void'(expected_reads.pop_front());
          n_checked++;
        end
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("debye_sum_accumulator: mismatch");
        $finish;
      end
    end
  end

  // item driver, with random gaps after an accepted item
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      start <= 1'b0;
    end else if (took && idle_on && $urandom_range(0, 3) == 0) begin
      gap_left = $urandom_range(0, 12);
      start <= 1'b0;
    end else if (pending.size() > 0) begin
      start <= 1'b1;
      item <= pending[0];
    end else begin
      start <= 1'b0;
    end
  end

  function automatic dsa_pkg::dsa_in_t make_item(input dsa_pkg::mode_t m, input int idx,
                                                  input int q, input int dist_q12,
                                                  input logic [31:0] w, input logic [31:0] mult,
                                                  input bit sc);
    dsa_pkg::dsa_in_t it;
    it.mode = m;
    it.point_index = idx[11:0];
    it.q_value = q[23:0];
    it.distance = dist_q12[21:0];
    it.weight = w;
    it.multiplicity = mult;
    it.use_scale = sc;
    return it;
  endfunction

  function automatic dsa_pkg::dsa_in_t random_item(input int n, input bit adds_ok);
    dsa_pkg::dsa_in_t it;
    int pick;
    int idx;
    it = make_item(dsa_pkg::MODE_READ, $urandom_range(0, NPTS - 1),
                   $urandom_range(0, 24'hFFFFFF),
                   $urandom_range(0, 1) ? $urandom_range(0, 22'h3FFFFF)
                                        : $urandom_range(0, 16'hFFFF),
                   $urandom, $urandom, $urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 40 && adds_ok) begin
      it.mode = dsa_pkg::MODE_ADD;
    end else if (pick < 60) begin
      it.mode = dsa_pkg::MODE_LOAD;
      // mostly reload active points so adds see new q values
      if (n > 0 && $urandom_range(0, 2) != 0) begin
        idx = $urandom_range(0, n - 1);
        it.point_index = idx[11:0];
      end
    end else if (pick < 63) begin
      it.mode = dsa_pkg::MODE_CLEAR;
    end else if (n > 0 && $urandom_range(0, 2) != 0) begin
      idx = $urandom_range(0, n - 1);
      it.point_index = idx[11:0];
    end
    return it;
  endfunction

  task automatic write_reg(input dsa_pkg::cfg_idx_t idx, input logic [19:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // hold off until all queued items are done and every read has come back
  task automatic drain();
    @(negedge clk);
    while (pending.size() != 0 || start || busy || expected_reads.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  // make sure every active q entry holds a written value before any add
  task automatic arm_points(input int n);
    for (int i = 0; i < n; i++)
      if (!loaded[i]) begin
        pending.push_back(make_item(dsa_pkg::MODE_LOAD, i, $urandom_range(0, 24'hFFFFFF),
                                    0, 0, 0, 0));
        loaded[i] = 1;
      end
  endtask

  task automatic random_phase(input int n, input int cnt, input bit adds_ok);
    dsa_pkg::dsa_in_t it;
    for (int i = 0; i < cnt; i++) begin
      it = random_item(n, adds_ok);
      pending.push_back(it);
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst = 1'b0;

    write_reg(dsa_pkg::CFG_NUM_POINTS, 20'd4);
    write_reg(dsa_pkg::CFG_LATTICE_SCALE, 20'd65536);
    pending.push_back(make_item(dsa_pkg::MODE_LOAD, 0, 0, 0, 0, 0, 0));
    pending.push_back(make_item(dsa_pkg::MODE_LOAD, 1, 24'hFFFFFF, 0, 0, 0, 0));
    pending.push_back(make_item(dsa_pkg::MODE_LOAD, 2, 24'h010000, 0, 0, 0, 0));
    pending.push_back(make_item(dsa_pkg::MODE_LOAD, 3, 24'h000001, 0, 0, 0, 0));
    pending.push_back(make_item(dsa_pkg::MODE_LOAD, 4095, 24'hFFFFFF, 0, 0, 0, 0));
    for (int i = 0; i < 4; i++) loaded[i] = 1;
    loaded[4095] = 1;
    pending.push_back(make_item(dsa_pkg::MODE_READ, 4095, 0, 0, 0, 0, 0));
    // self term at full weight and count
    pending.push_back(make_item(dsa_pkg::MODE_ADD, 0, 0, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 0));
    pending.push_back(make_item(dsa_pkg::MODE_ADD, 0, 0, 22'h3FFFFF, 32'hFFFFFFFF,
                                32'hFFFFFFFF, 1));
    pending.push_back(make_item(dsa_pkg::MODE_ADD, 0, 0, 22'h002800, 32'h40000000, 12, 0));
    pending.push_back(make_item(dsa_pkg::MODE_ADD, 0, 0, 22'h001000, 32'h40000000, 7, 1));
    for (int i = 0; i < 4; i++)
      pending.push_back(make_item(dsa_pkg::MODE_READ, i, 0, 0, 0, 0, 0));
    pending.push_back(make_item(dsa_pkg::MODE_READ, 4095, 0, 0, 0, 0, 0));
    pending.push_back(make_item(dsa_pkg::MODE_CLEAR, 0, 0, 0, 0, 0, 0));
    pending.push_back(make_item(dsa_pkg::MODE_READ, 1, 0, 0, 0, 0, 0));
    pending.push_back(make_item(dsa_pkg::MODE_ADD, 0, 0, 22'h0ABCDE, 0, 32'hFFFFFFFF, 1));
    pending.push_back(make_item(dsa_pkg::MODE_ADD, 0, 0, 22'h0ABCDE, 32'hFFFFFFFF, 0, 1));
    pending.push_back(make_item(dsa_pkg::MODE_READ, 2, 0, 0, 0, 0, 0));
    drain();

    write_reg(dsa_pkg::CFG_NUM_POINTS, 20'd1);
    write_reg(dsa_pkg::CFG_LATTICE_SCALE, 20'd0);
    arm_points(1);
    random_phase(1, 28, 1);
    drain();

    write_reg(dsa_pkg::CFG_NUM_POINTS, 20'd8);
    write_reg(dsa_pkg::CFG_LATTICE_SCALE, 20'hFFFFF);
    arm_points(8);
    random_phase(8, 28, 1);
    drain();

    write_reg(dsa_pkg::CFG_NUM_POINTS, 20'd0);
    write_reg(dsa_pkg::CFG_LATTICE_SCALE, 20'($urandom_range(0, 20'hFFFFF)));
    random_phase(0, 14, 1);
    drain();

    // full table and beyond it: no adds, since each would step through every point
    write_reg(dsa_pkg::CFG_NUM_POINTS, 20'd4096);
    random_phase(4096, 8, 0);
    drain();
    write_reg(dsa_pkg::CFG_NUM_POINTS, 20'hFFFFF);
    random_phase(4096, 6, 0);
    drain();

    write_reg(dsa_pkg::CFG_NUM_POINTS, 20'd3);
    write_reg(dsa_pkg::CFG_LATTICE_SCALE, 20'($urandom_range(20'h08000, 20'h40000)));
    arm_points(3);
    random_phase(3, 20, 1);
    drain();
    idle_on = 0;
    random_phase(3, 16, 1);
    drain();

    $display("covered %0d loads, %0d clears, %0d adds, %0d reads (%0d checked)",
             n_load, n_clear, n_add, n_read, n_checked);
    $display("over point counts 0..8, full and oversized tables, scales 0 to max");
    if (errors == 0 && expected_reads.size() == 0) begin
      $display("debye_sum_accumulator: match");
    end else begin
      $display("debye_sum_accumulator: mismatch");
    end
    $finish;
  end
endmodule
